/* src/knapsack_dp_with_traceback_defines.svh */
// Assertion helpers for the knapsack solver top module.
`ifndef KNAPSACK_DP_WITH_TRACEBACK_DEFINES_SVH
`define KNAPSACK_DP_WITH_TRACEBACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/kdp_pkg.sv */
package kdp_pkg;

  // Fixed field widths
  localparam int VALUE_W   = 16;
  localparam int CAP_REG_W = 11;
  localparam int VAL_W     = 21;
  localparam int MASK_W    = 32;

  // Default sizing
  localparam int DEF_MAX_ITEMS    = 32;
  localparam int DEF_MAX_CAPACITY = 1024;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TR_RD,
    ST_TR_EV,
    ST_DONE
  } kdp_state_e;

  // Store write controls
  typedef struct packed {
    logic we;   // write the given best value and take word
    logic clr;  // write zeros to both arrays
  } kdp_wr_t;

endpackage

/* src/knapsack_dp_with_traceback.sv */
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// input    in_valid_i/in_stall_o  item_value_i, item_weight_i, last_item_i
// output   out_valid_o/out_stall_i selected_mask_o, best_value_o, too_many_items_o
// config   cfg_we_i             cfg_wdata_i (capacity)
//
// An item sweeps columns C to 1 (C = min(capacity, MAX_CAPACITY)), one column of
// the row memory per cycle, each read and, if the item improves it, written
// back through the single write port. An item with C = 0 or beyond MAX_ITEMS
// skips the sweep. The last item adds a traceback of the n stored items, loads the
// result, then clears all MAX_CAPACITY+1 columns; reset starts the same pass.
// A stalled result is held in its register; new items are taken meanwhile.
`include "knapsack_dp_with_traceback_defines.svh"

module knapsack_dp_with_traceback #(
  parameter int MAX_ITEMS    = kdp_pkg::DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = kdp_pkg::DEF_MAX_CAPACITY
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kdp_pkg::CAP_REG_W-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kdp_pkg::VALUE_W-1:0]    item_value_i,
  input  logic [kdp_pkg::CAP_REG_W-1:0]  item_weight_i,
  input  logic                           last_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kdp_pkg::MASK_W-1:0]     selected_mask_o,
  output logic [kdp_pkg::VAL_W-1:0]      best_value_o,
  output logic                           too_many_items_o
);

  localparam int ADDR_W = $clog2(MAX_CAPACITY + 1);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int VW     = kdp_pkg::VAL_W;
  localparam int MW     = kdp_pkg::MASK_W;
  localparam int WW     = kdp_pkg::CAP_REG_W;
  localparam int NW     = kdp_pkg::VALUE_W;
  localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(MAX_CAPACITY);

  kdp_pkg::kdp_state_e state_q, state_d;

  // Control registers
  logic [WW-1:0]     capacity_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              p_vld_q, p_vld_d;

  // Payload registers
  logic [NW-1:0]        v_q, v_d;
  logic [WW-1:0]        w_q, w_d;
  logic                 last_q, last_d;
  logic [IDX_W-1:0]     k_q, k_d;
  logic [ADDR_W-1:0]    j_q, j_d;
  logic [ADDR_W-1:0]    p_col_q, p_col_d;
  logic                 p_fit_q, p_fit_d;
  logic [ADDR_W-1:0]    col_q, col_d;
  logic [CNT_W-1:0]     tk_q, tk_d;
  logic                 first_q, first_d;
  logic [MAX_ITEMS-1:0] mask_q, mask_d;
  logic [VW-1:0]        bestv_q, bestv_d;
  logic [MW-1:0]        out_mask_q, out_mask_d;
  logic [VW-1:0]        out_best_q, out_best_d;
  logic                 out_tmi_q, out_tmi_d;
  logic [WW-1:0]        wstore_q [MAX_ITEMS];
  logic                 ws_we;

  // Store interface
  logic [ADDR_W-1:0]    rd_a_addr, rd_b_addr, rd_t_addr, wr_addr;
  logic [VW-1:0]        rd_a, rd_b, wr_best;
  logic [MAX_ITEMS-1:0] rd_t, wr_take;
  kdp_pkg::kdp_wr_t     wr;

  // Derived values
  logic [ADDR_W-1:0] eff_cap;
  logic              room, fit, take, out_free;
  logic [VW-1:0]     cand;
  logic [CNT_W-1:0]  tk_m1;
  logic [IDX_W-1:0]  idx;
  logic [WW-1:0]     wsel;

  assign eff_cap  = (32'(capacity_q) > 32'(MAX_CAPACITY)) ? LAST_COL : ADDR_W'(capacity_q);
  assign room     = (count_q < CNT_W'(MAX_ITEMS));
  assign fit      = (32'(w_q) <= 32'(j_q));
  assign cand     = rd_b + VW'(v_q);
  assign take     = p_fit_q && (cand > rd_a);
  assign tk_m1    = tk_q - 1'b1;
  assign idx      = tk_m1[IDX_W-1:0];
  assign wsel     = wstore_q[idx];
  assign out_free = !out_valid_q || !out_stall_i;

  kdp_store #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_store (
    .clk_i       (clk_i),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_t_addr_i (rd_t_addr),
    .rd_a_data_o (rd_a),
    .rd_b_data_o (rd_b),
    .rd_t_data_o (rd_t),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .wr_best_i   (wr_best),
    .wr_take_i   (wr_take)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kdp_pkg::ST_CLEAR: begin
        if (clr_q == LAST_COL) state_d = kdp_pkg::ST_IDLE;
      end
      kdp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (room && (eff_cap != '0)) state_d = kdp_pkg::ST_SWEEP;
          else if (last_item_i)        state_d = kdp_pkg::ST_TR_RD;
        end
      end
      kdp_pkg::ST_SWEEP: begin
        if (j_q == ADDR_W'(1)) state_d = kdp_pkg::ST_DRAIN;
      end
      kdp_pkg::ST_DRAIN: begin
        state_d = last_q ? kdp_pkg::ST_TR_RD : kdp_pkg::ST_IDLE;
      end
      kdp_pkg::ST_TR_RD: state_d = kdp_pkg::ST_TR_EV;
      kdp_pkg::ST_TR_EV: begin
        state_d = (tk_q == '0) ? kdp_pkg::ST_DONE : kdp_pkg::ST_TR_RD;
      end
      kdp_pkg::ST_DONE: begin
        if (out_free) state_d = kdp_pkg::ST_CLEAR;
      end
      default: state_d = kdp_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    clr_d       = clr_q;
    p_vld_d     = 1'b0;
    v_d         = v_q;
    w_d         = w_q;
    last_d      = last_q;
    k_d         = k_q;
    j_d         = j_q;
    p_col_d     = p_col_q;
    p_fit_d     = p_fit_q;
    col_d       = col_q;
    tk_d        = tk_q;
    first_d     = first_q;
    mask_d      = mask_q;
    bestv_d     = bestv_q;
    out_mask_d  = out_mask_q;
    out_best_d  = out_best_q;
    out_tmi_d   = out_tmi_q;
    ws_we       = 1'b0;

    rd_a_addr = j_q;
    rd_b_addr = fit ? (j_q - ADDR_W'(w_q)) : j_q;
    rd_t_addr = j_q;

    // Write-back stage of the sweep
    wr      = '0;
    wr.we   = p_vld_q && take;
    wr_addr = p_col_q;
    wr_best = cand;
    wr_take = rd_t | (MAX_ITEMS'(1) << k_q);

    case (state_q)
      kdp_pkg::ST_CLEAR: begin
        wr.clr  = 1'b1;
        wr.we   = 1'b0;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      kdp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          v_d     = item_value_i;
          w_d     = item_weight_i;
          last_d  = last_item_i;
          k_d     = count_q[IDX_W-1:0];
          j_d     = eff_cap;
          col_d   = eff_cap;
          first_d = 1'b1;
          mask_d  = '0;
          if (room) begin
            ws_we   = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          tk_d = count_d;
        end
      end
      kdp_pkg::ST_SWEEP: begin
        p_vld_d = 1'b1;
        p_col_d = j_q;
        p_fit_d = fit;
        j_d     = j_q - 1'b1;
      end
      kdp_pkg::ST_TR_RD: begin
        rd_a_addr = col_q;
        rd_t_addr = col_q;
      end
      kdp_pkg::ST_TR_EV: begin
        if (first_q) begin
          bestv_d = rd_a;
          first_d = 1'b0;
        end
        if (tk_q != '0) begin
          if (rd_t[idx]) begin
            mask_d[idx] = 1'b1;
            col_d = (32'(wsel) > 32'(col_q)) ? '0 : (col_q - ADDR_W'(wsel));
          end
          tk_d = tk_m1;
        end
      end
      kdp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mask_d  = MW'(mask_q);
          out_best_d  = bestv_q;
          out_tmi_d   = ovf_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          clr_d       = '0;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kdp_pkg::ST_CLEAR;
      capacity_q  <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      p_vld_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) capacity_q <= cfg_wdata_i;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      p_vld_q     <= p_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    w_q        <= w_d;
    last_q     <= last_d;
    k_q        <= k_d;
    j_q        <= j_d;
    p_col_q    <= p_col_d;
    p_fit_q    <= p_fit_d;
    col_q      <= col_d;
    tk_q       <= tk_d;
    first_q    <= first_d;
    mask_q     <= mask_d;
    bestv_q    <= bestv_d;
    out_mask_q <= out_mask_d;
    out_best_q <= out_best_d;
    out_tmi_q  <= out_tmi_d;
  end

  // Item weights for the traceback
  always_ff @(posedge clk_i) begin
    if (ws_we) wstore_q[count_q[IDX_W-1:0]] <= item_weight_i;
  end

  assign in_stall_o       = (state_q != kdp_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign selected_mask_o  = out_mask_q;
  assign best_value_o     = out_best_q;
  assign too_many_items_o = out_tmi_q;

  // Checks
  `KDP_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_ITEMS), "item count overrun")
  `KDP_ASSERT_IMP(a_sweep_col, clk_i, rst_ni, state_q == kdp_pkg::ST_SWEEP, j_q != '0, "sweep reached column zero")
  `KDP_ASSERT_IMP(a_wb_follows_sweep, clk_i, rst_ni, p_vld_q, $past(state_q) == kdp_pkg::ST_SWEEP, "write-back without sweep read")
  `KDP_ASSERT_NXT(a_result_held, clk_i, rst_ni, (state_q == kdp_pkg::ST_DONE) && out_valid_q && out_stall_i, state_q == kdp_pkg::ST_DONE, "result overwrote a stalled one")
  `KDP_ASSERT_NXT(a_clear_no_write, clk_i, rst_ni, state_q == kdp_pkg::ST_CLEAR, !p_vld_q, "sweep write during clearing pass")

endmodule

/* src/kdp_store.sv */
// Row of best values and per-column take words, one entry per capacity.
module kdp_store #(
  parameter int MAX_ITEMS    = kdp_pkg::DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = kdp_pkg::DEF_MAX_CAPACITY
) (
  input  logic                         clk_i,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0] rd_a_addr_i,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0] rd_b_addr_i,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0] rd_t_addr_i,
  output logic [kdp_pkg::VAL_W-1:0]    rd_a_data_o,
  output logic [kdp_pkg::VAL_W-1:0]    rd_b_data_o,
  output logic [MAX_ITEMS-1:0]         rd_t_data_o,
  input  kdp_pkg::kdp_wr_t             wr_i,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0] wr_addr_i,
  input  logic [kdp_pkg::VAL_W-1:0]    wr_best_i,
  input  logic [MAX_ITEMS-1:0]         wr_take_i
);

  localparam int DEPTH = MAX_CAPACITY + 1;

  logic [kdp_pkg::VAL_W-1:0] best_mem [DEPTH];
  logic [MAX_ITEMS-1:0]      take_mem [DEPTH];

  // Single write port; clear forces zeros
  always_ff @(posedge clk_i) begin
    if (wr_i.we || wr_i.clr) begin
      best_mem[wr_addr_i] <= wr_i.clr ? '0 : wr_best_i;
      take_mem[wr_addr_i] <= wr_i.clr ? '0 : wr_take_i;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    rd_a_data_o <= best_mem[rd_a_addr_i];
    rd_b_data_o <= best_mem[rd_b_addr_i];
    rd_t_data_o <= take_mem[rd_t_addr_i];
  end

endmodule

/* verif/knapsack_dp_with_traceback_tb.sv */
module knapsack_dp_with_traceback_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W   = kdp_pkg::VALUE_W;
  localparam int CAP_REG_W = kdp_pkg::CAP_REG_W;
  localparam int VAL_W     = kdp_pkg::VAL_W;
  localparam int MASK_W    = kdp_pkg::MASK_W;
  localparam int MAXI      = kdp_pkg::DEF_MAX_ITEMS;
  localparam int MAXC      = kdp_pkg::DEF_MAX_CAPACITY;
  // clearing pass plus margin, waited out before a capacity write and at the end
  localparam int SETTLE_CYCLES = MAXC + 76;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [VAL_W-1:0]  value;
    logic              too_many;
  } solution_t;

  typedef struct packed {
    logic [CAP_REG_W-1:0] cap;
    logic [VALUE_W-1:0]   v;
    logic [CAP_REG_W-1:0] w;
    logic                 last;
    logic                 given;
    solution_t            sol;
  } dir_row_t;

  // DUT signals
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CAP_REG_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   item_value_i = '0;
  logic [CAP_REG_W-1:0] item_weight_i = '0;
  logic                 last_item_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [MASK_W-1:0]    selected_mask_o;
  logic [VAL_W-1:0]     best_value_o;
  logic                 too_many_items_o;

  knapsack_dp_with_traceback dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .item_value_i    (item_value_i),
    .item_weight_i   (item_weight_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .selected_mask_o (selected_mask_o),
    .best_value_o    (best_value_o),
    .too_many_items_o(too_many_items_o)
  );

  // DP solver state mirrored by the testbench
  logic [VAL_W-1:0]     dp_row [0:MAXC];
  bit                   take_map [0:MAXI-1][0:MAXC];
  logic [CAP_REG_W-1:0] item_weights [0:MAXI-1];
  int                   items_held = 0;
  bit                   dropped_items = 1'b0;
  logic [CAP_REG_W-1:0] capacity_reg = '0;

  solution_t expected_solutions [$];
  int        fails = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_ack = 1'b0;
  int        rx_busy = 0;

  // directed items; sol is typed in only where given is set
  dir_row_t directed_rows [0:14] = '{
    // zero capacity right after reset
    '{11'd0,    16'hFFFF, 11'd0,    1'b1, 1'b1, '{32'h0, 21'd0, 1'b0}},
    // exact fit
    '{11'd5,    16'd1,    11'd5,    1'b1, 1'b1, '{32'h1, 21'd1, 1'b0}},
    // over-capacity weight, zero weight with and without value
    '{11'd10,   16'd100,  11'd3,    1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd10,   16'd50,   11'd11,   1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd10,   16'd7,    11'd0,    1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd10,   16'd0,    11'd0,    1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd10,   16'd100,  11'd3,    1'b1, 1'b0, '{32'h0, 21'd0, 1'b0}},
    // tie keeps the earlier item
    '{11'd10,   16'd5,    11'd10,   1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd10,   16'd5,    11'd10,   1'b1, 1'b1, '{32'h1, 21'd5, 1'b0}},
    // capacity saturates, max weight never fits
    '{11'd2047, 16'd0,    11'd2047, 1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd2047, 16'hFFFF, 11'd1024, 1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd2047, 16'hFFFF, 11'd1024, 1'b1, 1'b1, '{32'h2, 21'd65535, 1'b0}},
    // full-size capacity
    '{11'd1024, 16'd40000, 11'd1000, 1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd1024, 16'd30000, 11'd24,   1'b0, 1'b0, '{32'h0, 21'd0, 1'b0}},
    '{11'd1024, 16'd50000, 11'd1001, 1'b1, 1'b0, '{32'h0, 21'd0, 1'b0}}
  };

  // capacity per random phase; -1 picks a small random one
  int phase_cap [11] = '{1, -1, 64, 1024, 0, -1, 2047, -1, -1, 3, -1};

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // clear the DP row, take bits and counters for a new problem
  function automatic void dp_clear();
    for (int j = 0; j <= MAXC; j++) begin
      dp_row[j] = '0;
      for (int k = 0; k < MAXI; k++) take_map[k][j] = 1'b0;
    end
    items_held = 0;
    dropped_items = 1'b0;
  endfunction

  // one item through the DP sweep; on the last item, traceback and solution
  function automatic bit dp_accept_item(input logic [VALUE_W-1:0] v,
                                        input logic [CAP_REG_W-1:0] w,
                                        input bit l, output solution_t sol);
    int eff;
    int col;
    logic [VAL_W-1:0] cand;
    eff = (int'(capacity_reg) > MAXC) ? MAXC : int'(capacity_reg);
    sol = '0;
    if (items_held < MAXI) begin
      for (int j = eff; j >= 1; j--) begin
        if (w <= j) begin
          cand = dp_row[j - w] + v;
          if (cand > dp_row[j]) begin
            dp_row[j] = cand;
            take_map[items_held][j] = 1'b1;
          end
        end
      end
      item_weights[items_held] = w;
      items_held++;
    end else begin
      dropped_items = 1'b1;
    end
    if (!l) return 1'b0;
    col = eff;
    sol.value = dp_row[col];
    for (int k = items_held - 1; k >= 0; k--) begin
      if (take_map[k][col]) begin
        sol.mask[k] = 1'b1;
        col = (item_weights[k] > col) ? 0 : col - item_weights[k];
      end
    end
    sol.too_many = dropped_items;
    dp_clear();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    fails++;
  endtask

  // offer one item, wait for the transfer, then maybe idle
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic [CAP_REG_W-1:0] w,
                           input bit l, input bit given, input solution_t given_sol);
    solution_t sol;
    int gap;
    in_valid_i    <= 1'b1;
    item_value_i  <= v;
    item_weight_i <= w;
    last_item_i   <= l;
    do @(posedge clk_i); while (in_stall_o);
    if (dp_accept_item(v, w, l, sol)) begin
      if (given) sol = given_sol;
      expected_solutions = {expected_solutions, sol};
    end
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every solution is back and the clear is done
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_solutions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_REG_W-1:0] c);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    capacity_reg = c;
  endtask

  // result receiver stall: random bursts, plus one long hold on request
  always @(posedge clk_i) begin : rx_stall
    int n;
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      rx_busy     <= 5000;
      out_stall_i <= 1'b1;
    end else if (rx_busy > 0) begin
      rx_busy     <= rx_busy - 1;
      out_stall_i <= 1'b1;
    end else begin
      n = idle_len();
      out_stall_i <= (n != 0);
      rx_busy     <= (n > 0) ? n - 1 : 0;
    end
  end

  // compare every result transfer with the oldest expected solution
  always @(posedge clk_i) begin : result_check
    solution_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_solutions.size() == 0) begin
        flag_mismatch("unexpected result", selected_mask_o, '0);
      end else begin
        want = expected_solutions.pop_front();
        if (selected_mask_o !== want.mask)
          flag_mismatch("selected_mask", selected_mask_o, want.mask);
        if (best_value_o !== want.value)
          flag_mismatch("best_value", 32'(best_value_o), 32'(want.value));
        if (too_many_items_o !== want.too_many)
          flag_mismatch("too_many_items", 32'(too_many_items_o), 32'(want.too_many));
      end
    end
  end

  initial begin
    int budget;
    int n;
    int eff;
    int kind;
    int sel;
    bit stuffed;
    bit first_problem;
    logic [VALUE_W-1:0] v;
    logic [CAP_REG_W-1:0] w;

    dp_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cap != capacity_reg) set_capacity(directed_rows[i].cap);
      send_item(directed_rows[i].v, directed_rows[i].w, directed_rows[i].last,
                directed_rows[i].given, directed_rows[i].sol);
    end

    // random phases, each under its own capacity
    foreach (phase_cap[p]) begin
      set_capacity(CAP_REG_W'((phase_cap[p] < 0) ? $urandom_range(2, 120) : phase_cap[p]));
      quiet = (p == 5);
      // long receiver hold while the sender keeps going
      if (p == 1) hold_req <= ~hold_req;
      eff = (int'(capacity_reg) > MAXC) ? MAXC : int'(capacity_reg);
      budget = (eff >= MAXC) ? 8 : 50;
      first_problem = 1'b1;
      while (budget > 0) begin
        kind = $urandom_range(0, 9);
        stuffed = 1'b0;
        if (eff == 1 && first_problem) begin
          // every item taken, then one too many
          n = MAXI + 1;
          stuffed = 1'b1;
        end else if (eff >= MAXC) begin
          n = $urandom_range(1, 4);
        end else if (kind == 0) begin
          n = $urandom_range(MAXI + 1, MAXI + 8);
        end else if (kind == 1) begin
          n = $urandom_range(9, MAXI);
        end else begin
          n = $urandom_range(1, 8);
        end
        for (int i = 0; i < n; i++) begin
          sel = $urandom_range(0, 7);
          case (sel)
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = VALUE_W'($urandom_range(1, 15));
            default: v = VALUE_W'($urandom());
          endcase
          sel = $urandom_range(0, 7);
          case (sel)
            0:       w = '0;
            1:       w = CAP_REG_W'(eff);
            2:       w = CAP_REG_W'($urandom_range(0, 2047));
            3:       w = CAP_REG_W'(eff + 1);
            default: w = CAP_REG_W'($urandom_range(0, (eff > 0) ? eff : 1));
          endcase
          if (stuffed) begin
            v = '1;
            w = '0;
          end
          send_item(v, w, i == n - 1, 1'b0, '0);
        end
        budget -= n;
        first_problem = 1'b0;
      end
    end

    drain_results();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
